// ===== hdl/wrench_moving_average_unit_macros.svh =====
// ---------------------------------------------------------------------------
// wrench moving average unit assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef WRENCH_MOVING_AVERAGE_UNIT_MACROS_SVH
`define WRENCH_MOVING_AVERAGE_UNIT_MACROS_SVH

// same cycle implication
`define WMA_ASSERT_IMPLY(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error(msg);

// next cycle implication
`define WMA_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== hdl/wma_pkg.sv =====
// ---------------------------------------------------------------------------
// wma_pkg
// shared widths, rounding constants and pipeline control struct
// ---------------------------------------------------------------------------
package wma_pkg;

    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 17;
    localparam int unsigned TENTH_W   = 13;
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned RND_BIAS  = 5;
    localparam int unsigned RND_RECIP = 52429;
    localparam int unsigned RND_SHIFT = 19;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic upd;
        logic full;
        logic sel3;
    } wma_ctrl_t;

endpackage

// ===== hdl/wma_ctrl.sv =====
// ---------------------------------------------------------------------------
// wma_ctrl
// pipeline valids and stalls, history slot pointer and fill counter
// ---------------------------------------------------------------------------
module wma_ctrl #(
    parameter int WINDOW = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic                      averaged,
    output wma_pkg::wma_ctrl_t        ctrl,
    output logic [$clog2(WINDOW)-1:0] slot
);
    import wma_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              sel2_reg, sel3_reg, sel4_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              adv1, adv2, adv3, adv4;
    logic              full;

    always_comb begin
        adv4 = !v4_reg || m_tready;
        adv3 = !v3_reg || adv4;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
        full = (fill_reg == FILL_W'(WINDOW));
        slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
        fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            sel2_reg <= 1'b0;
            sel3_reg <= 1'b0;
            sel4_reg <= 1'b0;
            slot_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg   <= v1_reg;
                sel2_reg <= full;
            end
            if (adv3) begin
                v3_reg   <= v2_reg;
                sel3_reg <= sel2_reg;
            end
            if (adv4) begin
                v4_reg   <= v3_reg;
                sel4_reg <= sel3_reg;
            end
            if (adv2 && v1_reg) begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_comb begin
        s_tready  = adv1;
        m_tvalid  = v4_reg;
        averaged  = sel4_reg;
        slot      = slot_reg;
        ctrl.ld1  = adv1;
        ctrl.ld2  = adv2;
        ctrl.ld3  = adv3;
        ctrl.ld4  = adv4;
        ctrl.upd  = adv2 && v1_reg;
        ctrl.full = full;
        ctrl.sel3 = sel3_reg;
    end

endmodule

// ===== hdl/wma_lane.sv =====
// ---------------------------------------------------------------------------
// wma_lane
// one channel: round to tenths, history window, running sum, scaled mean
// ---------------------------------------------------------------------------
module wma_lane #(
    parameter int WINDOW = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wma_pkg::wma_ctrl_t                ctrl,
    input  logic [$clog2(WINDOW)-1:0]         slot,
    input  logic signed [wma_pkg::IN_W-1:0]   sample_in,
    output logic signed [wma_pkg::OUT_W-1:0]  chan_out
);
    import wma_pkg::*;

    localparam int SUM_W     = TENTH_W + $clog2(WINDOW);
    localparam int SCL_W     = SUM_W + 4;
    localparam int DIV_SHIFT = SCL_W + 4;
    localparam int PROD_W    = SCL_W + DIV_SHIFT;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;

    // stage 1 round
    logic [IN_W-1:0]           mag_in, biased;
    logic [31:0]               rnd_prod;
    logic [TENTH_W-1:0]        rnd_mag;
    logic signed [TENTH_W-1:0] rnd_val;
    logic signed [TENTH_W-1:0] tenth1_reg;

    // stage 2 window
    logic signed [TENTH_W-1:0] hist_mem [WINDOW];
    logic signed [TENTH_W-1:0] oldest;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SUM_W-1:0]   sum2_reg;
    logic signed [OUT_W-1:0]   pass_val, pass2_reg, pass3_reg;

    // stage 3 divide
    logic signed [SCL_W-1:0]   scaled;
    logic [SCL_W-1:0]          scl_mag;
    logic [PROD_W-1:0]         div_prod;
    logic [QUO_W-1:0]          quo3_reg;
    logic                      neg3_reg;

    // stage 4 output
    logic signed [OUT_W-1:0]   mean_val;
    logic signed [OUT_W-1:0]   out4_reg;

    always_comb begin
        mag_in   = sample_in[IN_W-1] ? IN_W'(-sample_in) : IN_W'(sample_in);
        biased   = mag_in + IN_W'(RND_BIAS);
        rnd_prod = 32'(biased) * 32'(RND_RECIP);
        rnd_mag  = rnd_prod[RND_SHIFT +: TENTH_W];
        rnd_val  = sample_in[IN_W-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            tenth1_reg <= rnd_val;
        end
    end

    always_comb begin
        oldest   = ctrl.full ? hist_mem[slot] : '0;
        sum_next = sum_reg + SUM_W'(tenth1_reg) - SUM_W'(oldest);
        pass_val = (OUT_W'(tenth1_reg) <<< 3) + (OUT_W'(tenth1_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd) begin
            hist_mem[slot] <= tenth1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.upd) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld2) begin
            sum2_reg  <= sum_next;
            pass2_reg <= pass_val;
        end
    end

    always_comb begin
        scaled   = (SCL_W'(sum2_reg) <<< 3) + (SCL_W'(sum2_reg) <<< 1);
        scl_mag  = scaled[SCL_W-1] ? SCL_W'(-scaled) : SCL_W'(scaled);
        div_prod = PROD_W'(scl_mag) * PROD_W'(DIV_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld3) begin
            quo3_reg  <= div_prod[DIV_SHIFT +: QUO_W];
            neg3_reg  <= scaled[SCL_W-1];
            pass3_reg <= pass2_reg;
        end
    end

    always_comb begin
        mean_val = neg3_reg ? -$signed(OUT_W'(quo3_reg)) : $signed(OUT_W'(quo3_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld4) begin
            out4_reg <= ctrl.sel3 ? mean_val : pass3_reg;
        end
    end

    assign chan_out = out4_reg;

endmodule

// ===== hdl/wrench_moving_average_unit.sv =====
// ---------------------------------------------------------------------------
// wrench moving average unit
// rounds each force/torque channel to tenths and averages a sliding window
// ---------------------------------------------------------------------------
//  port group   dir   content
//  s_*          in    one sample word, CHANNELS x 16 bit signed hundredths
//  m_*          out   one filtered word, CHANNELS x 17 bit, tuser = averaged
//
//  four register stages, m_tvalid is the valid of the fourth
//  one word per cycle sustained while m_tready is high, set by the per-lane running sum
//  reset clears the fill counter, slot pointer, running sums and valids
//  a stall on m_tready holds the output; empty stages behind it still fill
// ---------------------------------------------------------------------------
`include "wrench_moving_average_unit_macros.svh"

module wrench_moving_average_unit #(
    parameter int WINDOW   = 10,
    parameter int CHANNELS = 6
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // force_x_in, force_y_in, force_z_in, torque_x_in, torque_y_in, torque_z_in
    input  logic [CHANNELS*wma_pkg::IN_W-1:0]       s_tdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // force_x_out, force_y_out, force_z_out, torque_x_out, torque_y_out,
    // torque_z_out, zero fill
    output logic [((CHANNELS*wma_pkg::OUT_W+7)/8)*8-1:0] m_tdata,
    // averaged
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready
);
    import wma_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);

    wma_ctrl_t               ctrl;
    logic [SLOT_W-1:0]       slot;
    logic signed [OUT_W-1:0] lane_out [CHANNELS];

    wma_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .averaged (m_tuser),
        .ctrl     (ctrl),
        .slot     (slot)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        wma_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .slot      (slot),
            .sample_in ($signed(s_tdata[c*IN_W +: IN_W])),
            .chan_out  (lane_out[c])
        );
    end

    always_comb begin
        m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            m_tdata[c*OUT_W +: OUT_W] = lane_out[c];
        end
    end

    `WMA_ASSERT_IMPLY(a_ready_when_drained, !m_tvalid, s_tready, "input stalled with empty output")
    `WMA_ASSERT_IMPLY(a_avg_needs_full, m_tvalid && m_tuser, ctrl.full, "mean before window filled")
    `WMA_ASSERT_NEXT(a_fill_saturates, ctrl.upd && ctrl.full, ctrl.full, "fill count left full")

endmodule
